>>> design/lds_pkg.sv
// Shared types, constants and arithmetic helpers for the log depth slice block.
// No dependencies; every other file imports this package.
package lds_pkg;

  localparam int LOG_FRACTION_BITS = 16;
  localparam int DEPTH_W  = 32;
  localparam int MSB_W    = 5;
  localparam int LOG_W    = MSB_W + LOG_FRACTION_BITS;
  localparam int CNT_W    = 13;
  localparam int PROD_W   = CNT_W + LOG_W;
  localparam int QUO_W    = 13;
  localparam int OUT_W    = 12;
  localparam int ADDR_W   = 4;
  localparam int STEP_W   = $clog2(LOG_FRACTION_BITS);

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SLICE_COUNT = 2'd0;
  localparam logic [1:0] REG_NEAR_DEPTH  = 2'd1;
  localparam logic [1:0] REG_FAR_DEPTH   = 2'd2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // one classified depth: zero flag, exponent and normalized mantissa (Q1.31)
  typedef struct packed {
    logic               zero;
    logic [MSB_W-1:0]   msb;
    logic [DEPTH_W-1:0] mant;
  } lds_item_t;

  typedef enum logic [1:0] {
    CL_IDLE,
    CL_LOAD,
    CL_SQUARE
  } cl_state_t;

  // position of the highest set bit (0 for zero input)
  function automatic logic [MSB_W-1:0] find_msb(input logic [DEPTH_W-1:0] x);
    logic [MSB_W-1:0] m;
    m = '0;
    for (int i = 0; i < DEPTH_W; i++) begin
      if (x[i]) m = MSB_W'(i);
    end
    return m;
  endfunction

  function automatic logic [DEPTH_W-1:0] normalize(input logic [DEPTH_W-1:0] x,
                                                   input logic [MSB_W-1:0] m);
    return x << (MSB_W'(DEPTH_W - 1) - m);
  endfunction

  // one squaring step: returns {fraction bit, new mantissa}
  function automatic logic [DEPTH_W:0] log_step(input logic [DEPTH_W-1:0] y);
    logic [2*DEPTH_W-1:0] sq;
    logic [DEPTH_W:0]     t;
    sq = {{DEPTH_W{1'b0}}, y} * {{DEPTH_W{1'b0}}, y};
    t  = sq[2*DEPTH_W-1:DEPTH_W-1];
    if (t[DEPTH_W]) begin
      return {1'b1, t[DEPTH_W:1]};
    end else begin
      return {1'b0, t[DEPTH_W-1:0]};
    end
  endfunction

endpackage

>>> design/lds_front.sv
// Front end: classifies an incoming depth and normalizes it for the log pipeline.
// Depends on lds_pkg.
module lds_front import lds_pkg::*; (
  input  logic [DEPTH_W-1:0] view_depth,
  input  logic [DEPTH_W-1:0] near_depth,
  input  logic               cfg_zero,
  output lds_item_t          item
);

  logic [MSB_W-1:0] msb;

  // exponent and mantissa; depths at or before near give slice 0
  always_comb begin
    msb       = find_msb(view_depth);
    item.zero = cfg_zero | (view_depth <= near_depth);
    item.msb  = msb;
    item.mant = normalize(view_depth, msb);
  end

endmodule

>>> design/lds_queue.sv
// Two-entry queue between the front end and the back-end pipeline.
// Depends on lds_pkg.
module lds_queue import lds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lds_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output lds_item_t head
);

  lds_item_t   mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> design/lds_cfg_log.sv
// Sequential log2 unit for the near and far planes, rerun after reset and plane writes.
// Depends on lds_pkg.
module lds_cfg_log import lds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DEPTH_W-1:0] near_depth,
  input  logic [DEPTH_W-1:0] far_depth,
  output logic               busy,
  output logic [LOG_W-1:0]   log_near,
  output logic [LOG_W-1:0]   log_far
);

  cl_state_t                   state_r, state_nxt;
  logic                        far_sel_r, far_sel_nxt;
  logic [DEPTH_W-1:0]          y_r;
  logic [LOG_FRACTION_BITS-1:0] frac_r;
  logic [MSB_W-1:0]            msb_r;
  logic [STEP_W-1:0]           step_r;
  logic [LOG_W-1:0]            ln_r, lf_r;
  logic [DEPTH_W-1:0]          operand;
  logic [MSB_W-1:0]            op_msb;
  logic [DEPTH_W:0]            ls;
  logic                        last_step;
  logic [LOG_FRACTION_BITS-1:0] frac_nxt;

  assign operand   = far_sel_r ? far_depth : near_depth;
  assign op_msb    = find_msb(operand);
  assign ls        = log_step(y_r);
  assign last_step = (step_r == STEP_W'(LOG_FRACTION_BITS - 1));
  assign frac_nxt  = {frac_r[LOG_FRACTION_BITS-2:0], ls[DEPTH_W]};
  assign busy      = (state_r != CL_IDLE);
  assign log_near  = ln_r;
  assign log_far   = lf_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CL_LOAD;
      far_sel_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      far_sel_r <= far_sel_nxt;
    end
  end

  // next state: near plane first, then far plane
  always_comb begin
    state_nxt   = state_r;
    far_sel_nxt = far_sel_r;
    if (start) begin
      state_nxt   = CL_LOAD;
      far_sel_nxt = 1'b0;
    end else begin
      case (state_r)
        CL_IDLE:   state_nxt = CL_IDLE;
        CL_LOAD:   state_nxt = CL_SQUARE;
        CL_SQUARE: begin
          if (last_step) begin
            state_nxt   = far_sel_r ? CL_IDLE : CL_LOAD;
            far_sel_nxt = 1'b1;
          end
        end
        default:   state_nxt = CL_IDLE;
      endcase
    end
  end

  // datapath: one squaring step per cycle
  always_ff @(posedge clk) begin
    if (state_r == CL_LOAD) begin
      msb_r  <= op_msb;
      y_r    <= normalize(operand, op_msb);
      frac_r <= '0;
      step_r <= '0;
    end else if (state_r == CL_SQUARE) begin
      y_r    <= ls[DEPTH_W-1:0];
      frac_r <= frac_nxt;
      step_r <= step_r + STEP_W'(1);
      if (last_step && !start) begin
        if (far_sel_r) lf_r <= {msb_r, frac_nxt};
        else           ln_r <= {msb_r, frac_nxt};
      end
    end
  end

endmodule

>>> design/lds_back.sv
// Back-end pipeline: squaring log stages, scale by count, restoring divide, clamp.
// Depends on lds_pkg.
module lds_back import lds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  lds_item_t        q_item,
  output logic             pop,
  input  logic [LOG_W-1:0] log_near,
  input  logic [LOG_W-1:0] log_den,
  input  logic [CNT_W-1:0] slice_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] slice_index
);

  localparam int F = LOG_FRACTION_BITS;

  logic en;

  // log stages
  logic                lg_vld_r  [F];
  logic                lg_zero_r [F];
  logic [MSB_W-1:0]    lg_msb_r  [F];
  logic [DEPTH_W-1:0]  lg_y_r    [F];
  logic [F-1:0]        lg_frac_r [F];

  // scale stage
  logic                mul_vld_r, mul_zero_r;
  logic [PROD_W-1:0]   mul_p_r;
  logic [LOG_W-1:0]    num;
  logic [PROD_W-1:0]   mul_prod;

  // divide stages
  logic                dv_vld_r  [QUO_W];
  logic                dv_zero_r [QUO_W];
  logic                dv_sat_r  [QUO_W];
  logic [PROD_W-1:0]   dv_rem_r  [QUO_W];
  logic [QUO_W-1:0]    dv_q_r    [QUO_W];

  // output register
  logic                out_vld_r;
  logic [OUT_W-1:0]    out_slice_r;
  logic [QUO_W-1:0]    quo, last, quo_cl;
  logic [OUT_W-1:0]    slice_fin;

  assign en          = !out_vld_r || out_ready;
  assign pop         = en && q_valid;
  assign out_valid   = out_vld_r;
  assign slice_index = out_slice_r;

  genvar s;
  generate
    for (s = 0; s < F; s++) begin : g_log
      logic               vi, zi;
      logic [MSB_W-1:0]   mi;
      logic [DEPTH_W-1:0] yi;
      logic [F-1:0]       fi;
      logic [DEPTH_W:0]   ls;
      if (s == 0) begin : g_first
        assign vi = q_valid;
        assign zi = q_item.zero;
        assign mi = q_item.msb;
        assign yi = q_item.mant;
        assign fi = '0;
      end else begin : g_next
        assign vi = lg_vld_r[s-1];
        assign zi = lg_zero_r[s-1];
        assign mi = lg_msb_r[s-1];
        assign yi = lg_y_r[s-1];
        assign fi = lg_frac_r[s-1];
      end
      assign ls = log_step(yi);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lg_vld_r[s] <= 1'b0;
        end else if (en) begin
          lg_vld_r[s] <= vi;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          lg_zero_r[s] <= zi;
          lg_msb_r[s]  <= mi;
          lg_y_r[s]    <= ls[DEPTH_W-1:0];
          lg_frac_r[s] <= {fi[F-2:0], ls[DEPTH_W]};
        end
      end
    end
  endgenerate

  // log difference times slice count
  assign num      = {lg_msb_r[F-1], lg_frac_r[F-1]} - log_near;
  assign mul_prod = PROD_W'(slice_count) * PROD_W'(num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= lg_vld_r[F-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_zero_r <= lg_zero_r[F-1];
      mul_p_r    <= mul_prod;
    end
  end

  // restoring divide, one quotient bit per stage, top bit first
  genvar j;
  generate
    for (j = 0; j < QUO_W; j++) begin : g_div
      localparam int K = QUO_W - 1 - j;
      logic              vi, zi, si;
      logic [PROD_W-1:0] ri, dsh;
      logic [QUO_W-1:0]  qi;
      logic              ge;
      if (j == 0) begin : g_first
        assign vi = mul_vld_r;
        assign zi = mul_zero_r;
        assign ri = mul_p_r;
        assign qi = '0;
        assign si = (mul_p_r >= {log_den, {QUO_W{1'b0}}});
      end else begin : g_next
        assign vi = dv_vld_r[j-1];
        assign zi = dv_zero_r[j-1];
        assign ri = dv_rem_r[j-1];
        assign qi = dv_q_r[j-1];
        assign si = dv_sat_r[j-1];
      end
      assign dsh = PROD_W'(log_den) << K;
      assign ge  = (ri >= dsh);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_vld_r[j] <= 1'b0;
        end else if (en) begin
          dv_vld_r[j] <= vi;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_zero_r[j] <= zi;
          dv_sat_r[j]  <= si;
          dv_rem_r[j]  <= ge ? (ri - dsh) : ri;
          dv_q_r[j]    <= qi | (QUO_W'(ge) << K);
        end
      end
    end
  endgenerate

  // clamp to the last slice and to the output range; zero items give slice 0
  always_comb begin
    quo    = dv_sat_r[QUO_W-1] ? {QUO_W{1'b1}} : dv_q_r[QUO_W-1];
    last   = slice_count - QUO_W'(1);
    quo_cl = (quo > last) ? last : quo;
    if (quo_cl > QUO_W'(OUT_MAX)) slice_fin = OUT_MAX;
    else                          slice_fin = quo_cl[OUT_W-1:0];
    if (dv_zero_r[QUO_W-1])       slice_fin = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_slice_r <= slice_fin;
  end

endmodule

>>> design/log_depth_slice_index.sv
// Top level of the logarithmic depth slice block: config registers and wiring.
// Depends on lds_pkg, lds_front, lds_queue, lds_cfg_log and lds_back.
//
// Usage: one unsigned Q16.16 view depth per input word (in_valid/in_ready),
// one 12-bit slice index per output word (out_valid/out_ready), in order.
// Throughput is one word per cycle while out_ready stays high and no plane log
// is being recomputed; the back end is a fully pipelined chain of squaring,
// scaling and divide stages. It has 16 log squaring stages (the first fed
// straight from the queue head), one scale stage, 13 divide stages and one
// output stage.
// When the receiver stalls, the whole back-end pipeline holds; the two-entry
// queue keeps taking words until it fills, then in_ready drops.
// After reset, and after each write of near_depth or far_depth, a sequential
// log unit recomputes both plane logs, near plane first, then far plane, with
// one squaring multiplier; in_ready stays low meanwhile. APB writes are taken
// at any time; slice_count takes effect at once.
module log_depth_slice_index import lds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DEPTH_W-1:0] in_view_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_slice_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0]   count_r;
  logic [DEPTH_W-1:0] near_r, far_r;
  logic               wr_en, cfg_start;
  logic               busy;
  logic [LOG_W-1:0]   log_near, log_far, log_den;
  logic               cfg_zero;
  lds_item_t          front_item, head_item;
  logic               q_full, q_valid, q_pop, push;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign cfg_start = wr_en && ((paddr[3:2] == REG_NEAR_DEPTH) ||
                               (paddr[3:2] == REG_FAR_DEPTH));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(24);
      near_r  <= DEPTH_W'(6554);
      far_r   <= DEPTH_W'(65536000);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SLICE_COUNT: count_r <= pwdata[CNT_W-1:0];
        REG_NEAR_DEPTH:  near_r  <= pwdata;
        REG_FAR_DEPTH:   far_r   <= pwdata;
        default:         ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_SLICE_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_r};
      REG_NEAR_DEPTH:  prdata = near_r;
      REG_FAR_DEPTH:   prdata = far_r;
      default:         prdata = '0;
    endcase
  end

  // plane logs and cases that force slice 0
  lds_cfg_log u_cfg_log (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cfg_start),
    .near_depth (near_r),
    .far_depth  (far_r),
    .busy       (busy),
    .log_near   (log_near),
    .log_far    (log_far)
  );

  assign log_den  = log_far - log_near;
  assign cfg_zero = (count_r == '0) || (near_r == '0) || (far_r <= near_r) ||
                    (log_den == '0);

  // front end and queue
  assign in_ready = !q_full && !busy;
  assign push     = in_valid && in_ready;

  lds_front u_front (
    .view_depth (in_view_depth),
    .near_depth (near_r),
    .cfg_zero   (cfg_zero),
    .item       (front_item)
  );

  lds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  lds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (head_item),
    .pop         (q_pop),
    .log_near    (log_near),
    .log_den     (log_den),
    .slice_count (count_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .slice_index (out_slice_index)
  );

endmodule

>>> verif/log_depth_slice_index_tb.sv
// Self-checking testbench for log_depth_slice_index: random depth stream, APB register
// phases, per-word slice prediction and in-order compare. Depends on lds_pkg and the RTL.
module log_depth_slice_index_tb;
  import lds_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [DEPTH_W-1:0] in_view_depth;
  logic               out_valid;
  logic               out_ready;
  logic [OUT_W-1:0]   out_slice_index;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  // predictor copy of the registers
  logic [CNT_W-1:0]   slice_count_q;
  logic [DEPTH_W-1:0] near_q;
  logic [DEPTH_W-1:0] far_q;

  logic [DEPTH_W-1:0] depth_queue[$];
  logic [OUT_W-1:0]   slice_queue[$];
  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  quiet_cycles;

  log_depth_slice_index i_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // truncated log2 with LOG_FRACTION_BITS fraction bits, by repeated squaring
  function automatic logic [LOG_W-1:0] log2_fixed(input logic [DEPTH_W-1:0] x);
    logic [MSB_W-1:0]     top;
    logic [63:0]          y;
    logic [LOG_FRACTION_BITS-1:0] frac;
    top  = '0;
    frac = '0;
    for (int i = 0; i < DEPTH_W; i++) if (x[i]) top = MSB_W'(i);
    y = 64'(x) << (31 - top);
    for (int i = 0; i < LOG_FRACTION_BITS; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {top, frac};
  endfunction

  function automatic logic [OUT_W-1:0] depth_slice(input logic [DEPTH_W-1:0] d);
    logic [63:0] ln;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] s;
    if (slice_count_q == 0 || near_q == 0 || d <= near_q || far_q <= near_q) return '0;
    ln  = 64'(log2_fixed(near_q));
    num = 64'(log2_fixed(d)) - ln;
    den = 64'(log2_fixed(far_q)) - ln;
    if (den == 0 || num == 0) return '0;
    s = (64'(slice_count_q) * num) / den;
    if (s > 64'(slice_count_q) - 1) s = 64'(slice_count_q) - 1;
    if (s > 4095) s = 4095;
    return s[OUT_W-1:0];
  endfunction

  task automatic report(input string what, input logic [OUT_W-1:0] got,
                        input logic [OUT_W-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver: presents queued depths, holds each word until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else if (depth_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid      <= 1'b1;
      in_view_depth <= depth_queue.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) slice_queue.push_back(depth_slice(in_view_depth));
      if (out_valid && out_ready) begin
        if (slice_queue.size() == 0) report("unexpected word", out_slice_index, '0);
        else begin
          if (out_slice_index !== slice_queue[0])
            report("slice_index", out_slice_index, slice_queue[0]);
          void'(slice_queue.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else if (depth_queue.size() > 0 || slice_queue.size() > 0 || in_valid) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SLICE_COUNT: slice_count_q = val[CNT_W-1:0];
      REG_NEAR_DEPTH:  near_q = val;
      default:         far_q = val;
    endcase
  endtask

  task automatic set_planes(input logic [CNT_W-1:0] cnt, input logic [31:0] nr,
                            input logic [31:0] fr);
    cfg_write(REG_SLICE_COUNT, 32'(cnt));
    cfg_write(REG_NEAR_DEPTH, nr);
    cfg_write(REG_FAR_DEPTH, fr);
  endtask

  // waits until the pipeline has drained
  task automatic drain();
    while (depth_queue.size() > 0 || in_valid || slice_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random depth, mostly between the planes, some across the full range
  function automatic logic [31:0] rand_depth();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60 && far_q > near_q)
      return near_q + 32'(33'($urandom) % (33'(far_q - near_q) + 33'd1));
    if (r < 75) return $urandom >> $urandom_range(31);
    if (r < 80) return near_q + $urandom_range(2) - 1;
    return $urandom;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) depth_queue.push_back(rand_depth());
    drain();
  endtask

  initial begin
    errors = 0; quiet_cycles = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_view_depth = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    slice_count_q = 13'd24; near_q = 32'd6554; far_q = 32'd65536000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset planes, field extremes, near edge, past far
    depth_queue = '{32'h0, 32'h1, 32'd6553, 32'd6554, 32'd6555, 32'h0001_0000,
                    32'd65535999, 32'd65536000, 32'd65536001, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    drain();
    // zero count
    set_planes(13'd0, 32'd6554, 32'd65536000);
    depth_queue = '{32'h0010_0000, 32'hFFFF_FFFF};
    drain();
    // far not beyond near, and far equal near
    set_planes(13'd16, 32'h0010_0000, 32'h0008_0000);
    depth_queue = '{32'h0020_0000, 32'hFFFF_FFFF};
    drain();
    set_planes(13'd16, 32'h0010_0000, 32'h0010_0000);
    depth_queue = '{32'h0020_0000};
    drain();
    // zero near plane
    set_planes(13'd16, 32'h0, 32'h0100_0000);
    depth_queue = '{32'h1, 32'h0080_0000};
    drain();
    // zero log span: far just past near
    set_planes(13'd16, 32'h8000_0000, 32'h8000_0001);
    depth_queue = '{32'h8000_0001, 32'hFFFF_FFFF};
    drain();
    // count above 4096, widest planes
    set_planes(13'h1FFF, 32'h1, 32'hFFFF_FFFF);
    depth_queue = '{32'h2, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    drain();

    // random phases across settings and idling
    set_planes(13'd24, 32'd6554, 32'd65536000);
    random_phase(300, 0, 0);
    set_planes(13'd4096, 32'h1, 32'hFFFF_FFFF);
    random_phase(300, 62, 0);
    set_planes(13'd1, 32'h0000_8000, 32'h0100_0000);
    random_phase(250, 0, 62);
    set_planes(13'($urandom_range(1, 4096)), 32'($urandom_range(1, 32'h0010_0000)),
               32'($urandom_range(32'h0010_0001, 32'hFFFF_FFFF)));
    random_phase(300, 20, 20);
    // receiver hold-off while sender keeps going
    set_planes(13'd64, 32'h0000_4000, 32'h4000_0000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 150; i++) depth_queue.push_back(rand_depth());
    hold_cycles = 200;
    drain();
    for (int k = 0; k < 4; k++) begin
      set_planes(13'($urandom_range(0, 8191)), $urandom, $urandom);
      random_phase(150, (k % 2) ? 62 : 0, (k > 1) ? 62 : 0);
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lds_pkg.sv
design/lds_front.sv
design/lds_queue.sv
design/lds_cfg_log.sv
design/lds_back.sv
design/log_depth_slice_index.sv
verif/log_depth_slice_index_tb.sv
